### rtl/gcc_pkg.sv
// Shared constants, types and helpers of the greedy coin change block.
package gcc_pkg;

  // Configuration slots and how many of them take part.
  localparam int NUM_SLOTS    = 8;
  localparam int NUM_DENOMS   = 8;   // 1 .. 8
  localparam int AMOUNT_WIDTH = 16;  // 8 .. 32

  localparam int DENOM_WIDTH = 16;
  localparam int FIELD_WIDTH = 16;
  localparam int CFG_IDX_W   = 4;
  localparam int SLOT_IDX_W  = $clog2(NUM_SLOTS);
  localparam int IDX_W       = (NUM_DENOMS > 1) ? $clog2(NUM_DENOMS) : 1;
  localparam int CNT_W       = $clog2(NUM_DENOMS + 1);

  // Divider datapath widths.
  localparam int REM_W  = ((AMOUNT_WIDTH > DENOM_WIDTH) ? AMOUNT_WIDTH : DENOM_WIDTH) + 1;
  localparam int STEP_W = $clog2(AMOUNT_WIDTH + 1);
  localparam int SAT_W  = (AMOUNT_WIDTH > FIELD_WIDTH) ? AMOUNT_WIDTH : FIELD_WIDTH + 1;

  // Status codes of the final result.
  localparam logic [1:0] STATUS_EXACT   = 2'd0;
  localparam logic [1:0] STATUS_PARTIAL = 2'd1;
  localparam logic [1:0] STATUS_NONE    = 2'd2;

  typedef logic [NUM_SLOTS-1:0][DENOM_WIDTH-1:0]  slot_arr_t;
  typedef logic [NUM_DENOMS-1:0][DENOM_WIDTH-1:0] sorted_arr_t;

  // Sorter status toward the sequencer.
  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] count;
  } sort_res_t;

  // Clamp an amount-wide value to a 16-bit result field.
  function automatic logic [FIELD_WIDTH-1:0] sat16(input logic [AMOUNT_WIDTH-1:0] v);
    logic [SAT_W-1:0] w;
    w = SAT_W'(v);
    if (w > SAT_W'({FIELD_WIDTH{1'b1}})) begin
      return {FIELD_WIDTH{1'b1}};
    end
    return w[FIELD_WIDTH-1:0];
  endfunction

endpackage

### rtl/gcc_sorter.sv
// Insertion sorter: orders the nonzero denomination slots largest first, one slot a cycle.
module gcc_sorter (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  gcc_pkg::slot_arr_t  denoms,
  output gcc_pkg::sorted_arr_t sorted,
  output gcc_pkg::sort_res_t  res
);

  logic                       busy;
  logic [gcc_pkg::IDX_W-1:0]  slot;
  logic [gcc_pkg::CNT_W-1:0]  count;
  logic                       done;
  logic [gcc_pkg::DENOM_WIDTH-1:0] d;
  logic [gcc_pkg::NUM_DENOMS-1:0]  ge;
  gcc_pkg::sorted_arr_t       sorted_next;

  assign d = denoms[gcc_pkg::SLOT_IDX_W'(slot)];

  // Entries at or above the new value keep their place; the rest shift down.
  // Empty entries hold zero, which is always below a used denomination.
  always_comb begin
    for (int j = 0; j < gcc_pkg::NUM_DENOMS; j++) begin
      ge[j] = (sorted[j] >= d);
    end
    for (int j = 0; j < gcc_pkg::NUM_DENOMS; j++) begin
      if (ge[j]) begin
        sorted_next[j] = sorted[j];
      end else if (j == 0) begin
        sorted_next[j] = d;
      end else if (ge[j-1]) begin
        sorted_next[j] = d;
      end else begin
        sorted_next[j] = sorted[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        slot   <= '0;
        count  <= '0;
        sorted <= '0;
      end else if (busy) begin
        if (d != '0) begin
          sorted <= sorted_next;
          count  <= count + gcc_pkg::CNT_W'(1);
        end
        slot <= slot + gcc_pkg::IDX_W'(1);
        if (slot == gcc_pkg::IDX_W'(gcc_pkg::NUM_DENOMS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done  = done;
  assign res.count = count;

endmodule

### rtl/gcc_divider.sv
// Restoring divider: one quotient bit per cycle, shared by all denominations.
module gcc_divider (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [gcc_pkg::AMOUNT_WIDTH-1:0]    dividend,
  input  logic [gcc_pkg::DENOM_WIDTH-1:0]     divisor,
  output logic                                done,
  output logic [gcc_pkg::AMOUNT_WIDTH-1:0]    quotient,
  output logic [gcc_pkg::AMOUNT_WIDTH-1:0]    remainder
);

  logic                               busy;
  logic [gcc_pkg::STEP_W-1:0]         steps;
  logic [gcc_pkg::DENOM_WIDTH-1:0]    dvsr;
  logic [gcc_pkg::REM_W-1:0]          part;
  logic [gcc_pkg::REM_W-1:0]          trial;
  logic                               fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {part[gcc_pkg::REM_W-2:0], quotient[gcc_pkg::AMOUNT_WIDTH-1]};
  assign fits  = (trial >= gcc_pkg::REM_W'(dvsr));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        steps    <= gcc_pkg::STEP_W'(gcc_pkg::AMOUNT_WIDTH);
        dvsr     <= divisor;
        part     <= '0;
        quotient <= dividend;
      end else if (busy) begin
        part     <= fits ? (trial - gcc_pkg::REM_W'(dvsr)) : trial;
        quotient <= {quotient[gcc_pkg::AMOUNT_WIDTH-2:0], fits};
        steps    <= steps - gcc_pkg::STEP_W'(1);
        if (steps == gcc_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The final remainder is below the divisor and no larger than the dividend.
  assign remainder = part[gcc_pkg::AMOUNT_WIDTH-1:0];

endmodule

### rtl/greedy_coin_change.sv
// Top level of the greedy coin change block: config slots, sequencer and output register.
//
//  channel  handshake              payload
//  -------  ---------------------  ----------------------------------------------
//  in       in_valid / in_ready    amount
//  out      out_valid / out_ready  denomination, coin_count, total_coins,
//                                  shortfall, status, last
//  cfg      cfg_we (no wait)       cfg_index, cfg_data
//
// The sort walks one slot a cycle; each denomination then costs one pass of the
// bit-serial divider, one quotient bit a cycle. in_ready is high only while the
// sequencer is idle. Reset clears the denomination slots and the control state. A
// stalled result holds in the output register, and the next division waits until
// it is taken.
module greedy_coin_change (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [gcc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gcc_pkg::DENOM_WIDTH-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [15:0]                       amount,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [15:0]                       denomination,
  output logic [15:0]                       coin_count,
  output logic [15:0]                       total_coins,
  output logic [15:0]                       shortfall,
  output logic [1:0]                        status,
  output logic                              last
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SORT = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t                                state;
  gcc_pkg::slot_arr_t                    denom_reg;
  gcc_pkg::sorted_arr_t                  sorted;
  gcc_pkg::sort_res_t                    sort_res;
  logic [gcc_pkg::AMOUNT_WIDTH-1:0]      remainder;
  logic [gcc_pkg::AMOUNT_WIDTH-1:0]      coin_total;
  logic [gcc_pkg::AMOUNT_WIDTH-1:0]      coin_total_next;
  logic [gcc_pkg::IDX_W-1:0]             idx;
  logic [gcc_pkg::IDX_W-1:0]             div_idx;
  logic                                  sort_start;
  logic                                  div_start;
  logic                                  div_done;
  logic [gcc_pkg::AMOUNT_WIDTH-1:0]      div_quot;
  logic [gcc_pkg::AMOUNT_WIDTH-1:0]      div_rem;
  logic                                  fin;
  logic [1:0]                            status_fin;

  assign in_ready   = (state == ST_IDLE);
  assign sort_start = in_valid && in_ready;

  // Kick the divider right after the sort, and again each time a non-final
  // result leaves. The dividend is always the running remainder.
  assign div_start = ((state == ST_SORT) && sort_res.done && (sort_res.count != '0)) ||
                     ((state == ST_OUT) && out_ready && !last);
  assign div_idx   = (state == ST_OUT) ? (idx + gcc_pkg::IDX_W'(1)) : '0;

  gcc_sorter u_sorter (
    .clk    (clk),
    .rst    (rst),
    .start  (sort_start),
    .denoms (denom_reg),
    .sorted (sorted),
    .res    (sort_res)
  );

  gcc_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (remainder),
    .divisor   (sorted[div_idx]),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // Totals as they stand once the current division lands.
  assign coin_total_next = coin_total + div_quot;
  assign fin = ((gcc_pkg::CNT_W'(idx) + gcc_pkg::CNT_W'(1)) == sort_res.count);

  always_comb begin
    if (coin_total_next == '0) begin
      status_fin = gcc_pkg::STATUS_NONE;
    end else if (div_rem == '0) begin
      status_fin = gcc_pkg::STATUS_EXACT;
    end else begin
      status_fin = gcc_pkg::STATUS_PARTIAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      denom_reg <= '0;
    end else begin
      // Drop writes beyond the slot list.
      if (cfg_we && (cfg_index < gcc_pkg::CFG_IDX_W'(gcc_pkg::NUM_SLOTS))) begin
        denom_reg[gcc_pkg::SLOT_IDX_W'(cfg_index)] <= cfg_data;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            remainder  <= gcc_pkg::AMOUNT_WIDTH'(amount);
            coin_total <= '0;
            state      <= ST_SORT;
          end
        end

        ST_SORT: begin
          if (sort_res.done) begin
            idx <= '0;
            if (sort_res.count == '0) begin
              // No denomination in use: one empty result.
              denomination <= '0;
              coin_count   <= '0;
              total_coins  <= '0;
              shortfall    <= gcc_pkg::sat16(remainder);
              status       <= gcc_pkg::STATUS_NONE;
              last         <= 1'b1;
              out_valid    <= 1'b1;
              state        <= ST_OUT;
            end else begin
              state <= ST_DIV;
            end
          end
        end

        ST_DIV: begin
          if (div_done) begin
            remainder    <= div_rem;
            coin_total   <= coin_total_next;
            denomination <= sorted[idx];
            coin_count   <= gcc_pkg::sat16(div_quot);
            total_coins  <= fin ? gcc_pkg::sat16(coin_total_next) : '0;
            shortfall    <= fin ? gcc_pkg::sat16(div_rem) : '0;
            status       <= fin ? status_fin : gcc_pkg::STATUS_EXACT;
            last         <= fin;
            out_valid    <= 1'b1;
            state        <= ST_OUT;
          end
        end

        ST_OUT: begin
          // Hold the result until taken, then advance or finish.
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last) begin
              state <= ST_IDLE;
            end else begin
              idx   <= idx + gcc_pkg::IDX_W'(1);
              state <= ST_DIV;
            end
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### tb/sv/greedy_coin_change_checker.sv
// Checker for the greedy coin change block: watches the channels, predicts and compares.
`timescale 1ns / 100ps

module greedy_coin_change_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [gcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [15:0]                   amount,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [15:0]                   denomination,
  input  logic [15:0]                   coin_count,
  input  logic [15:0]                   total_coins,
  input  logic [15:0]                   shortfall,
  input  logic [1:0]                    status,
  input  logic                          last,
  output int                            fail_count,
  output int                            outstanding,
  output int                            amounts_seen,
  output int                            results_seen
);

  typedef struct {
    logic [15:0] amt;
    logic [15:0] denomination;
    logic [15:0] coin_count;
    logic [15:0] total_coins;
    logic [15:0] shortfall;
    logic [1:0]  status;
    logic        last;
  } coin_rec_t;

  logic [15:0] denom_slot [gcc_pkg::NUM_SLOTS];
  coin_rec_t   change_q [$];
  int          mismatches = 0;

  assign fail_count = mismatches;

  function automatic logic [15:0] clamp16(input logic [63:0] v);
    return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  // Sort the used slots largest first, then break the amount greedily.
  function automatic void predict_change(input logic [15:0] amt);
    logic [15:0] order [gcc_pkg::NUM_SLOTS];
    logic [63:0] counts [gcc_pkg::NUM_SLOTS];
    logic [63:0] rest;
    logic [63:0] tally;
    logic [1:0]  fin_status;
    coin_rec_t   rec;
    int          used;
    int          i;
    int          j;
    used  = 0;
    tally = '0;
    rest  = 64'(amt) & ((64'd1 << gcc_pkg::AMOUNT_WIDTH) - 64'd1);
    for (i = 0; i < gcc_pkg::NUM_DENOMS; i++) begin
      if (denom_slot[i] != 16'd0) begin
        j = used;
        while (j > 0 && order[j-1] < denom_slot[i]) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = denom_slot[i];
        used++;
      end
    end
    rec.amt = amt;
    if (used == 0) begin
      rec.denomination = '0;
      rec.coin_count   = '0;
      rec.total_coins  = '0;
      rec.shortfall    = clamp16(rest);
      rec.status       = gcc_pkg::STATUS_NONE;
      rec.last         = 1'b1;
      change_q.push_back(rec);
      return;
    end
    for (i = 0; i < used; i++) begin
      counts[i] = '0;
      if (64'(order[i]) <= rest) begin
        counts[i] = rest / 64'(order[i]);
        rest      = rest % 64'(order[i]);
        tally     = tally + counts[i];
      end
    end
    if (tally == 64'd0) fin_status = gcc_pkg::STATUS_NONE;
    else if (rest == 64'd0) fin_status = gcc_pkg::STATUS_EXACT;
    else fin_status = gcc_pkg::STATUS_PARTIAL;
    for (i = 0; i < used; i++) begin
      rec.denomination = order[i];
      rec.coin_count   = clamp16(counts[i]);
      rec.last         = (i == used - 1);
      rec.total_coins  = rec.last ? clamp16(tally) : 16'd0;
      rec.shortfall    = rec.last ? clamp16(rest) : 16'd0;
      rec.status       = rec.last ? fin_status : gcc_pkg::STATUS_EXACT;
      change_q.push_back(rec);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] amt,
                                 input logic [31:0] want, input logic [31:0] got);
    if (mismatches < 40)
      $display("%0t: mismatch in %s for amount %0d: expected %0d, got %0d",
               $time, what, amt, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    coin_rec_t want;
    if (rst) begin
      foreach (denom_slot[k]) denom_slot[k] = '0;
      change_q.delete();
      outstanding  <= 0;
      amounts_seen <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_we && cfg_index < gcc_pkg::CFG_IDX_W'(gcc_pkg::NUM_SLOTS))
        denom_slot[gcc_pkg::SLOT_IDX_W'(cfg_index)] = cfg_data;
      if (in_valid && in_ready) begin
        predict_change(amount);
        amounts_seen <= amounts_seen + 1;
      end
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (change_q.size() == 0) begin
          report_mismatch("result with nothing expected", 16'd0, 32'd0, 32'(denomination));
        end else begin
          want = change_q.pop_front();
          if (denomination !== want.denomination)
            report_mismatch("denomination", want.amt, 32'(want.denomination),
                            32'(denomination));
          if (coin_count !== want.coin_count)
            report_mismatch("coin_count", want.amt, 32'(want.coin_count), 32'(coin_count));
          if (total_coins !== want.total_coins)
            report_mismatch("total_coins", want.amt, 32'(want.total_coins), 32'(total_coins));
          if (shortfall !== want.shortfall)
            report_mismatch("shortfall", want.amt, 32'(want.shortfall), 32'(shortfall));
          if (status !== want.status)
            report_mismatch("status", want.amt, 32'(want.status), 32'(status));
          if (last !== want.last)
            report_mismatch("last", want.amt, 32'(want.last), 32'(last));
        end
      end
      outstanding <= change_q.size();
    end
  end

endmodule

### tb/sv/greedy_coin_change_tb.sv
// Testbench top of the greedy coin change block: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module greedy_coin_change_tb;

  // The limit covers the whole run and lies far beyond what it needs, stalls and gaps included.
  localparam int CYCLE_LIMIT     = 800_000;
  localparam int SETTLE_CYCLES   = 20;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 50;

  // Denomination slot k sits at register index DENOM_BASE_IDX + k.
  localparam logic [gcc_pkg::CFG_IDX_W-1:0] DENOM_BASE_IDX = '0;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [gcc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]                   cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [15:0]                   amount = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [15:0]                   denomination;
  logic [15:0]                   coin_count;
  logic [15:0]                   total_coins;
  logic [15:0]                   shortfall;
  logic [1:0]                    status;
  logic                          last;

  int          fail_count;
  int          outstanding;
  int          amounts_seen;
  int          results_seen;
  int          cycles = 0;
  int          settings_used = 0;
  int          rx_hold = 0;
  logic        rx_eager = 1'b0;
  logic        tx_eager = 1'b0;
  logic [15:0] plan [gcc_pkg::NUM_SLOTS];

  greedy_coin_change u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .amount       (amount),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .denomination (denomination),
    .coin_count   (coin_count),
    .total_coins  (total_coins),
    .shortfall    (shortfall),
    .status       (status),
    .last         (last)
  );

  greedy_coin_change_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .amount       (amount),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .denomination (denomination),
    .coin_count   (coin_count),
    .total_coins  (total_coins),
    .shortfall    (shortfall),
    .status       (status),
    .last         (last),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .amounts_seen (amounts_seen),
    .results_seen (results_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort a hung run: a lost result or a stuck handshake ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results still expected", cycles, outstanding);
      $display("status: fail");
      $finish;
    end
  end

  // Result side: after each transaction drop ready for a random hold counted down in
  // rx_hold, or keep it high throughout while rx_eager is set.
  always @(posedge clk) begin : rx_pace
    int hold;
    if (rst) begin
      out_ready <= 1'b0;
      rx_hold   <= 0;
    end else if (out_ready && out_valid) begin
      hold = rx_eager ? 0 : $urandom_range(0, 10);
      if (hold != 0) begin
        out_ready <= 1'b0;
        rx_hold   <= hold;
      end
    end else if (!out_ready) begin
      if (rx_hold <= 1) out_ready <= 1'b1;
      rx_hold <= rx_hold - 1;
    end
  end

  // Offer one amount after a random gap and hold it until the transaction.
  // Valid stays high afterwards so a back-to-back item need not drop and raise it;
  // callers that stop sending drop it through wait_drained.
  task automatic send_amount(input logic [15:0] a);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    amount   <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and hold off until every predicted result has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Load all eight slots from plan while the block is idle, then aim one write at
  // an index past the slots, which the block must ignore.
  task automatic apply_plan();
    int k;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (k = 0; k < gcc_pkg::NUM_SLOTS; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= DENOM_BASE_IDX + gcc_pkg::CFG_IDX_W'(k);
      cfg_data  <= plan[k];
      @(posedge clk);
    end
    cfg_index <= gcc_pkg::CFG_IDX_W'(gcc_pkg::NUM_SLOTS +
                 $urandom_range(0, (1 << gcc_pkg::CFG_IDX_W) - 1 - gcc_pkg::NUM_SLOTS));
    cfg_data  <= 16'($urandom_range(1, 16'hFFFF));
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [15:0] random_denom();
    case ($urandom_range(0, 9))
      0, 1:    return 16'd0;
      2:       return 16'd1;
      3:       return 16'hFFFF;
      4, 5:    return 16'($urandom_range(1, 12));
      6, 7:    return 16'($urandom_range(13, 500));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] random_amount();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(0, 200));
      4, 5:    return 16'($urandom_range(0, 5000));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int p;
    int n;
    int k;
    logic [15:0] same;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // No slot in use after reset: one empty result, shortfall equals the amount.
    settings_used++;
    send_amount(16'd0);
    send_amount(16'hFFFF);
    send_amount(16'h5555);

    // Unsorted slots with a one among them: always exact, amount zero gives none.
    plan = '{16'd0, 16'd10, 16'd25, 16'd1, 16'd0, 16'd5, 16'd0, 16'd0};
    apply_plan();
    send_amount(16'd41);
    send_amount(16'd0);
    send_amount(16'hFFFF);

    // Every slot used, extreme values and a duplicate: the later twin gets nothing.
    plan = '{16'hFFFF, 16'hFFFF, 16'd1, 16'h8000, 16'd7, 16'd3, 16'd2, 16'd100};
    apply_plan();
    send_amount(16'hFFFF);
    send_amount(16'h7FFF);
    send_amount(16'd1);

    // A single denomination in the top slot: none formed, exact and partial.
    plan = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd9};
    apply_plan();
    send_amount(16'd8);
    send_amount(16'd9);
    send_amount(16'd20);
    send_amount(16'hAAAA);

    // Denominations above the remainder still report a zero count.
    plan = '{16'd500, 16'd0, 16'd0, 16'd300, 16'd0, 16'd0, 16'd0, 16'd0};
    apply_plan();
    send_amount(16'd299);
    send_amount(16'd800);
    send_amount(16'd1234);

    // Random settings, a few of them shaped: all slots equal, and all slots clear.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      same = random_denom();
      for (k = 0; k < gcc_pkg::NUM_SLOTS; k++) begin
        if (p == 3) plan[k] = same;
        else if (p == 6) plan[k] = 16'd0;
        else plan[k] = random_denom();
      end
      apply_plan();
      tx_eager = (p % 3 == 1);
      rx_eager <= (p % 3 == 2);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_amount(random_amount());
        // Now and then let the block run dry mid-phase.
        if ($urandom_range(0, 24) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d amounts across %0d denomination settings, stray indexes included",
             amounts_seen, settings_used);
    $display("compared %0d results field by field, %0d mismatches", results_seen, fail_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
